// ----- rtl/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, codes and constants for the servo command line parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int MAX_GROUPS = 16;
  localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

  // Result kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_STOP   = 3'd1;
  localparam logic [2:0] KIND_SERVO  = 3'd2;
  localparam logic [2:0] KIND_STATUS = 3'd3;
  localparam logic [2:0] KIND_PULSEQ = 3'd4;

  // Character codes
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [2:0] STOP_LEN  = 3'd4;
  localparam logic [2:0] STOP_FAIL = 3'd7;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_GEN_Q    = 4'd1,
    PH_GEN_DIG  = 4'd2,
    PH_GEN_IGN  = 4'd3,
    PH_SV_CHAN  = 4'd4,
    PH_SV_SKIP  = 4'd5,
    PH_SV_PULSE = 4'd6,
    PH_SV_SPEED = 4'd7,
    PH_SV_TIME  = 4'd8,
    PH_SV_IDLE  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    CS_RUN   = 2'd0,
    CS_FETCH = 2'd1,
    CS_EMIT  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0]  channel;
    logic [15:0] pulse;
    logic [15:0] speed;
    logic        speed_given;
  } group_t;

  // Controller -> datapath
  typedef struct packed {
    logic step;        // parse one ordinary character
    logic single;      // line end with one result, clears line
    logic idx_clr;     // start of group drain
    logic idx_inc;     // next group
    logic load_group;  // load current group into output register
    logic clear_line;  // drain done
  } scp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_cr;
    logic servo_drain;
    logic out_free;
    logic last_group;
  } scp_sts_t;

  function automatic logic [7:0] stop_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_S;
      2'd1:    c = CH_T;
      2'd2:    c = CH_O;
      default: c = CH_P;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/scp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_ctrl
// Sequencer: character parsing, line end, drain of stored groups.
// ----------------------------------------------------------------------------
module scp_ctrl import scp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  scp_sts_t sts,
  output scp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_RUN: begin
        if (in_valid && in_ready && sts.is_cr && sts.servo_drain) begin
          state_nxt = CS_FETCH;
        end
      end
      CS_FETCH: state_nxt = CS_EMIT;
      CS_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_group ? CS_RUN : CS_FETCH;
        end
      end
      default: state_nxt = CS_RUN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      CS_RUN: begin
        // a line end with one result needs the output register free
        in_ready = !sts.is_cr || sts.servo_drain || sts.out_free;
        if (in_valid && in_ready) begin
          if (!sts.is_cr) begin
            cmd.step = 1'b1;
          end else if (sts.servo_drain) begin
            cmd.idx_clr = 1'b1;
          end else begin
            cmd.single = 1'b1;
          end
        end
      end
      CS_FETCH: ;
      CS_EMIT: begin
        if (sts.out_free) begin
          cmd.load_group = 1'b1;
          cmd.clear_line = sts.last_group;
          cmd.idx_inc    = !sts.last_group;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/scp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_datapath
// Line parse registers, group store and output register.
// ----------------------------------------------------------------------------
module scp_datapath import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_char_code,
  input  scp_cmd_t    cmd,
  output scp_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_channel,
  output logic [15:0] out_pulse_width,
  output logic [15:0] out_speed,
  output logic        out_speed_given,
  output logic [15:0] out_move_time,
  output logic        out_time_given,
  output logic        out_dropped,
  output logic        out_last
);

  // line state
  phase_t           phase_r, phase_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [2:0]       stop_r, stop_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      time_r, time_nxt;
  logic             tgiven_r, tgiven_nxt;
  logic             ovf_r, ovf_nxt;
  group_t           cur_r, cur_nxt;

  // group store: holds all but the newest group, which lives in cur_r
  group_t           store [MAX_GROUPS];
  group_t           rd_data_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic [7:0]       c;
  logic             c_digit;
  logic [19:0]      acc_prod;
  logic [15:0]      acc_sat;
  logic             grp_ok;

  // output register
  logic             ov_r;
  logic [2:0]       o_kind_r;
  logic [7:0]       o_chan_r;
  logic [15:0]      o_pulse_r, o_speed_r, o_time_r;
  logic             o_sg_r, o_tg_r, o_drop_r, o_last_r;
  group_t           emit_grp;

  assign c        = in_char_code;
  assign c_digit  = (c >= CH_0) && (c <= CH_9);
  assign acc_prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, c[3:0]};
  assign acc_sat  = (acc_prod > 20'd65535) ? 16'hFFFF : acc_prod[15:0];
  assign cnt_m1   = count_r - CNT_W'(1);
  assign grp_ok   = !ovf_r && (count_r != '0);

  assign sts.is_cr       = (c == CH_CR);
  assign sts.servo_drain = (kind_r == KIND_SERVO) && (count_r != '0);
  assign sts.out_free    = !ov_r || out_ready;
  assign sts.last_group  = (idx_r == cnt_m1[IDX_W-1:0]);

  // character step and line clear
  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    stop_nxt   = stop_r;
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    time_nxt   = time_r;
    tgiven_nxt = tgiven_r;
    ovf_nxt    = ovf_r;
    cur_nxt    = cur_r;
    wr_en      = 1'b0;
    wr_idx     = cnt_m1[IDX_W-1:0];

    if (cmd.step) begin
      if (kind_r != KIND_SERVO) begin
        if (stop_r < STOP_LEN && c == stop_char(stop_r[1:0])) begin
          stop_nxt = stop_r + 3'd1;
        end else begin
          stop_nxt = STOP_FAIL;
        end
      end

      // line start: '#' opens a group, 'Q' a status query, anything else a pulse width query
      if (phase_r == PH_START) begin
        acc_nxt = '0;
        if (c == CH_HASH) begin
          kind_nxt  = KIND_SERVO;
          phase_nxt = PH_SV_CHAN;
          cur_nxt   = '0;
          count_nxt = count_r + CNT_W'(1);
        end else if (c == CH_Q) begin
          kind_nxt  = KIND_STATUS;
          phase_nxt = PH_GEN_Q;
        end else begin
          kind_nxt  = KIND_PULSEQ;
          phase_nxt = PH_GEN_DIG;
        end
      end else if (kind_r == KIND_SERVO) begin
        if (phase_r == PH_SV_CHAN) begin
          if (grp_ok) cur_nxt.channel = c - CH_0;
          phase_nxt = PH_SV_SKIP;
        end else if (phase_r == PH_SV_SKIP) begin
          acc_nxt   = '0;
          phase_nxt = PH_SV_PULSE;
        end else if ((phase_r == PH_SV_PULSE || phase_r == PH_SV_SPEED ||
                      phase_r == PH_SV_TIME) && c_digit) begin
          acc_nxt = acc_sat;
          if (phase_r == PH_SV_TIME) begin
            time_nxt = acc_sat;
          end else if (grp_ok && phase_r == PH_SV_PULSE) begin
            cur_nxt.pulse = acc_sat;
          end else if (grp_ok) begin
            cur_nxt.speed = acc_sat;
          end
        end else begin
          // command character dispatch
          acc_nxt = '0;
          if (c == CH_HASH) begin
            phase_nxt = PH_SV_CHAN;
            if (count_r < CNT_W'(MAX_GROUPS)) begin
              wr_en     = (count_r != '0);
              cur_nxt   = '0;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (c == CH_T) begin
            time_nxt   = '0;
            tgiven_nxt = 1'b1;
            phase_nxt  = PH_SV_TIME;
          end else if (c == CH_S) begin
            if (grp_ok) begin
              cur_nxt.speed       = '0;
              cur_nxt.speed_given = 1'b1;
            end
            phase_nxt = PH_SV_SPEED;
          end else begin
            phase_nxt = PH_SV_IDLE;
          end
        end
      end else begin
        if (phase_r == PH_GEN_Q) begin
          if (c == CH_P) begin
            kind_nxt  = KIND_PULSEQ;
            phase_nxt = PH_GEN_DIG;
          end else begin
            phase_nxt = PH_GEN_IGN;
          end
        end else if (phase_r == PH_GEN_DIG) begin
          if (c_digit) acc_nxt = acc_sat;
          else phase_nxt = PH_GEN_IGN;
        end
      end
    end

    if (cmd.single || cmd.clear_line) begin
      phase_nxt  = PH_START;
      kind_nxt   = KIND_NONE;
      stop_nxt   = '0;
      acc_nxt    = '0;
      count_nxt  = '0;
      time_nxt   = '0;
      tgiven_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      kind_r   <= KIND_NONE;
      stop_r   <= '0;
      acc_r    <= '0;
      count_r  <= '0;
      time_r   <= '0;
      tgiven_r <= 1'b0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      stop_r   <= stop_nxt;
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      time_r   <= time_nxt;
      tgiven_r <= tgiven_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) store[wr_idx] <= cur_r;
    rd_data_r <= store[idx_r];
  end

  assign emit_grp = sts.last_group ? cur_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.single || cmd.load_group) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      o_chan_r  <= '0;
      o_pulse_r <= '0;
      o_speed_r <= '0;
      o_sg_r    <= 1'b0;
      o_time_r  <= '0;
      o_tg_r    <= 1'b0;
      o_drop_r  <= 1'b0;
      o_last_r  <= 1'b1;
      if (stop_r == STOP_LEN) begin
        o_kind_r <= KIND_STOP;
      end else if (kind_r == KIND_PULSEQ) begin
        o_kind_r <= KIND_PULSEQ;
        o_chan_r <= (acc_r > 16'd255) ? 8'hFF : acc_r[7:0];
      end else if (kind_r == KIND_STATUS) begin
        o_kind_r <= KIND_STATUS;
      end else begin
        o_kind_r <= KIND_NONE;
      end
    end else if (cmd.load_group) begin
      o_kind_r  <= KIND_SERVO;
      o_chan_r  <= emit_grp.channel;
      o_pulse_r <= emit_grp.pulse;
      o_speed_r <= emit_grp.speed;
      o_sg_r    <= emit_grp.speed_given;
      o_time_r  <= time_r;
      o_tg_r    <= tgiven_r;
      o_drop_r  <= ovf_r;
      o_last_r  <= sts.last_group;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = o_kind_r;
  assign out_channel     = o_chan_r;
  assign out_pulse_width = o_pulse_r;
  assign out_speed       = o_speed_r;
  assign out_speed_given = o_sg_r;
  assign out_move_time   = o_time_r;
  assign out_time_given  = o_tg_r;
  assign out_dropped     = o_drop_r;
  assign out_last        = o_last_r;

endmodule

// ----- rtl/servo_command_line_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_line_parser_core
// Character-at-a-time parser for servo controller command lines.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one character per transfer; carriage return ends a line.
//   out_* carries result items: one per line end, or one per stored servo
//   group on a move line, with out_last set on the final one.
// Timing:
//   Ordinary characters: one per cycle outside a move-line drain, no result.
//   Line end with a single result: the result is in the output register the
//   cycle after the transfer; the next character is taken meanwhile.
//   Move line with N groups: after the carriage return the sequencer steps
//   through a fetch state (one store read) and an emit state (one load of
//   the output register) per group; in_ready is low for the whole drain.
// Reset: rst_n low returns the parser to line start with no result pending.
// Stall: a held result keeps its value; ordinary characters still transfer,
//   but a single-result line end (and a move-line drain) waits for the output register.
// ----------------------------------------------------------------------------
module servo_command_line_parser_core import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_channel,
  output logic [15:0] out_pulse_width,
  output logic [15:0] out_speed,
  output logic        out_speed_given,
  output logic [15:0] out_move_time,
  output logic        out_time_given,
  output logic        out_dropped,
  output logic        out_last
);

  scp_cmd_t cmd;   // sequencer commands
  scp_sts_t sts;   // datapath status

  // Sequencer: run / fetch / emit
  scp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Parse registers, group store, output register
  scp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_code    (in_char_code),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_channel     (out_channel),
    .out_pulse_width (out_pulse_width),
    .out_speed       (out_speed),
    .out_speed_given (out_speed_given),
    .out_move_time   (out_move_time),
    .out_time_given  (out_time_given),
    .out_dropped     (out_dropped),
    .out_last        (out_last)
  );

endmodule

// ----- rtl/scp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the servo command line parser.
// ----------------------------------------------------------------------------
module scp_checker import scp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_channel,
  input logic [15:0] out_pulse_width,
  input logic [15:0] out_speed,
  input logic        out_speed_given,
  input logic [15:0] out_move_time,
  input logic        out_time_given,
  input logic        out_dropped,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_channel) && $stable(out_pulse_width) && $stable(out_speed) &&
      $stable(out_move_time) && $stable(out_last))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= KIND_PULSEQ)
    else $error("bad result kind");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SERVO |-> out_last && !out_dropped &&
      !out_speed_given && !out_time_given && out_pulse_width == 16'd0)
    else $error("non-move result malformed");

  a_line_end_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_char_code != CH_CR && !in_ready |->
      $past(in_valid && in_ready && in_char_code == CH_CR) || !out_last ||
      $past(!in_ready))
    else $error("ordinary character stalled outside a drain");

endmodule

bind servo_command_line_parser_core scp_checker u_scp_checker (.*);

// ----- tb/servo_command_line_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_line_parser_core_tb
// Self-checking bench for the servo command line parser core.
// Sends short directed command lines, then random ones: move lines (some past
// group capacity), stop variants, status and pulse width queries, empty and
// garbage lines. A behavioral parser predicts every result. Each result
// transfer is checked in order. Both sides idle at random, and the result side
// holds off once for a long stretch so that a line end stalls the input.
// ----------------------------------------------------------------------------
import scp_pkg::*;

typedef struct packed {
  logic [2:0]  kind;
  logic [7:0]  channel;
  logic [15:0] pulse_width;
  logic [15:0] speed;
  logic        speed_given;
  logic [15:0] move_time;
  logic        time_given;
  logic        dropped;
  logic        last;
} cmd_result_t;

class command_line_checker;
  cmd_result_t expected_results[$];
  int          failures;

  // parser state
  phase_t      phase;
  logic [2:0]  line_kind;
  logic [2:0]  stop_pos;
  logic [15:0] acc;
  logic [7:0]  grp_channel [MAX_GROUPS];
  logic [15:0] grp_pulse [MAX_GROUPS];
  logic [15:0] grp_speed [MAX_GROUPS];
  logic        grp_speed_given [MAX_GROUPS];
  int          grp_count;
  logic [15:0] line_time;
  logic        time_given;
  logic        overflow;
  logic [7:0]  stop_word [4];

  function new();
    failures  = 0;
    stop_word = '{CH_S, CH_T, CH_O, CH_P};
    clear_line();
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void expect_result(cmd_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function void clear_line();
    phase      = PH_START;
    line_kind  = KIND_NONE;
    stop_pos   = '0;
    acc        = '0;
    grp_count  = 0;
    line_time  = '0;
    time_given = 1'b0;
    overflow   = 1'b0;
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function void add_digit(logic [7:0] c);
    int unsigned v;
    v   = 32'(acc) * 10 + 32'(c - CH_0);
    acc = (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // no group to write once capacity has been exceeded
  function bit group_live();
    return !overflow && grp_count > 0 && grp_count <= MAX_GROUPS;
  endfunction

  function void open_group();
    if (grp_count < MAX_GROUPS) begin
      grp_channel[grp_count]     = '0;
      grp_pulse[grp_count]       = '0;
      grp_speed[grp_count]       = '0;
      grp_speed_given[grp_count] = 1'b0;
      grp_count++;
    end else begin
      overflow = 1'b1;
    end
    phase = PH_SV_CHAN;
  endfunction

  // command character inside a move line; anything unknown parks the parser
  function void sv_dispatch(logic [7:0] c);
    acc = '0;
    if (c == CH_HASH) begin
      open_group();
    end else if (c == CH_T) begin
      line_time  = '0;
      time_given = 1'b1;
      phase      = PH_SV_TIME;
    end else if (c == CH_S) begin
      if (group_live()) begin
        grp_speed[grp_count - 1]       = '0;
        grp_speed_given[grp_count - 1] = 1'b1;
      end
      phase = PH_SV_SPEED;
    end else begin
      phase = PH_SV_IDLE;
    end
  endfunction

  function void close_line();
    cmd_result_t r;
    int          i;
    if (line_kind == KIND_SERVO && grp_count > 0) begin
      for (i = 0; i < grp_count; i++) begin
        r             = '0;
        r.kind        = KIND_SERVO;
        r.channel     = grp_channel[i];
        r.pulse_width = grp_pulse[i];
        r.speed       = grp_speed[i];
        r.speed_given = grp_speed_given[i];
        r.move_time   = line_time;
        r.time_given  = time_given;
        r.dropped     = overflow;
        r.last        = (i == grp_count - 1);
        expect_result(r);
      end
    end else begin
      r = '0;
      if (stop_pos == STOP_LEN) begin
        r.kind = KIND_STOP;
      end else if (line_kind == KIND_PULSEQ) begin
        r.kind    = KIND_PULSEQ;
        r.channel = (acc > 16'd255) ? 8'hFF : acc[7:0];
      end else if (line_kind == KIND_STATUS) begin
        r.kind = KIND_STATUS;
      end
      r.last = 1'b1;
      expect_result(r);
    end
    clear_line();
  endfunction

  // one accepted character
  function void take_char(logic [7:0] c);
    bit live;
    if (c == CH_CR) begin
      close_line();
      return;
    end
    if (line_kind != KIND_SERVO) begin
      if (stop_pos < STOP_LEN && c == stop_word[stop_pos[1:0]]) stop_pos++;
      else stop_pos = STOP_FAIL;
    end
    live = group_live();
    if (phase == PH_START) begin
      acc = '0;
      if (c == CH_HASH) begin
        line_kind = KIND_SERVO;
        open_group();
      end else if (c == CH_Q) begin
        line_kind = KIND_STATUS;
        phase     = PH_GEN_Q;
      end else begin
        line_kind = KIND_PULSEQ;
        phase     = PH_GEN_DIG;
      end
    end else if (line_kind == KIND_SERVO) begin
      case (phase)
        PH_SV_CHAN: begin
          if (live) grp_channel[grp_count - 1] = 8'(c - CH_0);
          phase = PH_SV_SKIP;
        end
        PH_SV_SKIP: begin
          acc   = '0;
          phase = PH_SV_PULSE;
        end
        PH_SV_PULSE, PH_SV_SPEED, PH_SV_TIME: begin
          if (!is_digit(c)) begin
            sv_dispatch(c);
          end else begin
            add_digit(c);
            if (phase == PH_SV_TIME) line_time = acc;
            else if (live && phase == PH_SV_PULSE) grp_pulse[grp_count - 1] = acc;
            else if (live) grp_speed[grp_count - 1] = acc;
          end
        end
        default: sv_dispatch(c);
      endcase
    end else begin
      case (phase)
        PH_GEN_Q: begin
          if (c == CH_P) begin
            line_kind = KIND_PULSEQ;
            phase     = PH_GEN_DIG;
          end else begin
            phase = PH_GEN_IGN;
          end
        end
        PH_GEN_DIG: begin
          if (is_digit(c)) add_digit(c);
          else phase = PH_GEN_IGN;
        end
        default: ;
      endcase
    end
  endfunction

  function string show(cmd_result_t r);
    return $sformatf("kind=%0d ch=%0d pw=%0d spd=%0d sg=%0d time=%0d tg=%0d drop=%0d last=%0d",
                     r.kind, r.channel, r.pulse_width, r.speed, r.speed_given,
                     r.move_time, r.time_given, r.dropped, r.last);
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function void match_result(cmd_result_t got);
    cmd_result_t want;
    if (expected_results.size() == 0) begin
      note_failure({"result with nothing pending: ", show(got)});
      return;
    end
    want = expected_results.pop_front();
    if (got !== want)
      note_failure({"result mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
  endfunction
endclass

module servo_command_line_parser_core_tb;

  localparam int SEND_TARGET = 370;   // random characters to send
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int HOLD_START  = 300;   // sink cycle at which the long hold begins
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_channel;
  logic [15:0] out_pulse_width;
  logic [15:0] out_speed;
  logic        out_speed_given;
  logic [15:0] out_move_time;
  logic        out_time_given;
  logic        out_dropped;
  logic        out_last;

  command_line_checker line_check;
  cmd_result_t         seen;
  logic [7:0]          line_buf[$];  // characters of the line being built
  logic                calm;         // no random idling on either side while set
  int                  quiet_cycles;
  int                  sink_cycles;

  always #2 clk = ~clk;

  servo_command_line_parser_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_channel     (out_channel),
    .out_pulse_width (out_pulse_width),
    .out_speed       (out_speed),
    .out_speed_given (out_speed_given),
    .out_move_time   (out_move_time),
    .out_time_given  (out_time_given),
    .out_dropped     (out_dropped),
    .out_last        (out_last)
  );

  // --------------------------------------------------------------------------
  // Line building helpers
  // --------------------------------------------------------------------------

  function automatic void append_char(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  // any byte but carriage return, so a line only ends where intended
  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
    return b;
  endfunction

  // up to six digits: five or six often saturate at 65535
  function automatic void add_digits(int n);
    repeat (n) append_char(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) append_char(s[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Character side: one transfer per call, random idle cycles ahead of it.
  // Inputs change on the falling edge; the transfer is seen at a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do begin
      @(posedge clk);
    end while (in_ready !== 1'b1);
    line_check.take_char(c);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold, counted here in
  // sink cycles. The input keeps offering characters during the hold, so the
  // next line end (or move-line drain) backs up into in_ready.
  // --------------------------------------------------------------------------
  initial begin
    out_ready   = 1'b0;
    sink_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      sink_cycles++;
      if (sink_cycles >= HOLD_START && sink_cycles < HOLD_START + HOLD_CYCLES)
        out_ready <= 1'b0;
      else
        out_ready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      seen.kind        = out_kind;
      seen.channel     = out_channel;
      seen.pulse_width = out_pulse_width;
      seen.speed       = out_speed;
      seen.speed_given = out_speed_given;
      seen.move_time   = out_move_time;
      seen.time_given  = out_time_given;
      seen.dropped     = out_dropped;
      seen.last        = out_last;
      line_check.match_result(seen);
    end
  end

  // watchdog: ends a run that stops moving on both channels
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         sent;
    int         pick;
    int         groups;
    int         parts;
    bit         big;
    logic [7:0] lead;

    line_check   = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    calm         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: exact stop, empty line, bare Q status, QP pulse query, and a
    // move line with a skipped letter, saturating pulse, speed and two times
    // (the second one wins).
    add_text("STOP");
    append_char(CH_CR);
    append_char(CH_CR);
    add_text("Q");
    append_char(CH_CR);
    add_text("QP7");
    append_char(CH_CR);
    add_text("#1x70000S9T3T1");
    append_char(CH_CR);
    send_line();

    // Random lines. The first is always a move line at or past group capacity.
    sent = 0;
    while (sent < SEND_TARGET) begin
      calm = (sent >= 120 && sent < 200);
      pick = $urandom_range(0, 99);
      if (sent == 0 || pick < 45) begin
        // move line; big ones hold exactly MAX_GROUPS groups or overflow it
        big    = (sent == 0 || pick < 5);
        groups = big ? MAX_GROUPS + $urandom_range(0, 3) : $urandom_range(1, 5);
        for (int g = 0; g < groups; g++) begin
          append_char(CH_HASH);
          parts = 3;
          if (big && $urandom_range(0, 1) == 0) parts = 0;
          else if (g == groups - 1 && $urandom_range(0, 9) == 0) parts = $urandom_range(0, 2);
          if (parts >= 1)  // channel, now and then a non-digit
            append_char(($urandom_range(0, 9) != 0) ?
                        8'(CH_0 + $urandom_range(0, 9)) : any_byte());
          if (parts >= 2) append_char(any_byte());  // skipped letter
          if (parts == 3) begin
            add_digits($urandom_range(0, 6));
            if ($urandom_range(0, 9) < 4) begin
              append_char(CH_S);
              add_digits($urandom_range(0, 6));
            end
            if ($urandom_range(0, 9) < 3) begin
              append_char(CH_T);
              add_digits($urandom_range(0, 6));
            end
            if ($urandom_range(0, 9) < 2) append_char(any_byte());
          end
        end
      end else if (pick < 54) begin
        // stop word, exact or spoiled
        add_text("STOP");
        case ($urandom_range(0, 3))
          1: repeat ($urandom_range(1, 3)) void'(line_buf.pop_back());
          2: append_char(any_byte());
          3: line_buf[$urandom_range(0, 3)] = any_byte();
          default: ;
        endcase
      end else if (pick < 63) begin
        // status query, or QP pulse width query
        append_char(CH_Q);
        case ($urandom_range(0, 2))
          1: begin
            append_char(CH_P);
            add_digits($urandom_range(0, 5));
            if ($urandom_range(0, 1) == 0) begin
              append_char(any_byte());
              add_digits($urandom_range(0, 3));
            end
          end
          2: begin
            append_char(any_byte());
            add_digits($urandom_range(0, 3));
          end
          default: ;
        endcase
      end else if (pick < 73) begin
        // pulse width query: any lead character but '#' or 'Q'
        do lead = any_byte(); while (lead == CH_HASH || lead == CH_Q);
        append_char(lead);
        add_digits($urandom_range(0, 5));
        if ($urandom_range(0, 2) == 0) begin
          append_char(any_byte());
          add_digits($urandom_range(0, 3));
        end
      end else if (pick >= 78) begin
        // garbage
        repeat ($urandom_range(1, 8)) append_char(any_byte());
      end
      // picks 73..77 leave the line empty
      append_char(CH_CR);
      sent += line_buf.size();
      send_line();
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then a margin for any stray result
    while (line_check.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (line_check.failures == 0 && line_check.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/scp_pkg.sv
rtl/scp_ctrl.sv
rtl/scp_datapath.sv
rtl/servo_command_line_parser_core.sv
rtl/scp_checker.sv
tb/servo_command_line_parser_core_tb.sv
